### hdl/tps_pkg.sv
// Shared constants, state encoding and helper functions of the TPS point evaluator.
// No dependencies; imported by tps_isqrt, tps_point_evaluation and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package tps_pkg;

    localparam int MaxPoints = 64;
    localparam int IdxW      = $clog2(MaxPoints);
    localparam int CntW      = $clog2(MaxPoints + 1);
    localparam int ValW      = 32;

    localparam logic [62:0] Cap63 = '1;

    localparam logic [1:0] MODE_POINT  = 2'd0;
    localparam logic [1:0] MODE_WEIGHT = 2'd1;
    localparam logic [1:0] MODE_AFFINE = 2'd2;
    localparam logic [1:0] MODE_QUERY  = 2'd3;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_AFF  = 9'b000000010,
        S_RD   = 9'b000000100,
        S_SQ   = 9'b000001000,
        S_SQRT = 9'b000010000,
        S_DSQ  = 9'b000100000,
        S_SD   = 9'b001000000,
        S_WT   = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    function automatic logic [30:0] diff_mag(logic [31:0] a, logic [31:0] b);
        logic [32:0] d;
        logic [32:0] m;
        d = {a[31], a} - {b[31], b};
        m = d[32] ? (~d + 33'd1) : d;
        return (m > 33'h07FFFFFFF) ? 31'h7FFFFFFF : m[30:0];
    endfunction

    function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, Cap63};
        return s[63:0];
    endfunction

    function automatic logic [31:0] sat_out(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'h7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

### hdl/tps_point_evaluation.sv
// Top level of the 3D thin-plate spline evaluator: stores, sequencer, shared multiplier.
// Depends on tps_pkg and tps_isqrt.
// Write items are accepted only while idle. A query runs the affine map (skipped with
// skip_affine), then a step per active control point (root step, one 33x33 multiplier),
// then loads the output register; ready stays low meanwhile and until a full output register frees up.
// Reset clears the sequencer, the output register and point_count; the stores are not reset.
`timescale 1ns / 1ps
`default_nettype none
module tps_point_evaluation
    import tps_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [6:0]   cfg_data,     // point_count
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [135:0] s_tdata,      // index, val_0, val_1, val_2, val_3, zero pad
    input  wire logic [2:0]   s_tuser,      // mode, skip_affine
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata       // out_x, out_y, out_z
);

    state_t state_reg;
    logic [CntW-1:0] point_count_reg;
    logic [CntW-1:0] n_pts;
    logic [CntW-1:0] pidx_reg;
    logic [1:0]  row_reg;
    logic [1:0]  term_reg;
    logic        part_reg;
    logic        phase_reg;

    logic [95:0]  pt_mem [MaxPoints];
    logic [95:0]  wt_mem [MaxPoints];
    logic [127:0] aff_mem [3];
    logic [95:0]  pt_rd_reg;
    logic [95:0]  wt_rd_reg;

    logic [31:0] qx_reg, qy_reg, qz_reg;
    logic [63:0] acc_reg [3];
    logic [63:0] sum_reg;
    logic [31:0] d_reg;
    logic [47:0] s_reg;
    logic [62:0] u_reg;
    logic [95:0] wide_reg;
    logic signed [65:0] prod_reg;
    logic        out_valid_reg;
    logic [95:0] out_data_reg;

    logic signed [32:0] mul_a, mul_b;
    logic [IdxW-1:0] in_index;
    logic [1:0]  in_mode;
    logic [31:0] v0, v1, v2, v3;
    logic        in_acc;
    logic        out_load;
    logic [31:0] coef, coord, pcoord, wsel, wmag;
    logic [30:0] dm;
    logic [95:0] full;
    logic [79:0] rsh;
    logic [62:0] rsat;
    logic [63:0] wterm;
    logic [63:0] aff_p;
    logic        sq_start, sq_done;
    logic [31:0] sq_root;

    assign in_index = s_tdata[IdxW-1:0];
    assign v0       = s_tdata[37:6];
    assign v1       = s_tdata[69:38];
    assign v2       = s_tdata[101:70];
    assign v3       = s_tdata[133:102];
    assign in_mode  = s_tuser[1:0];
    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign n_pts = (point_count_reg > CntW'(MaxPoints)) ? CntW'(MaxPoints) : point_count_reg;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    always_ff @(posedge clk)
    begin
        if (in_acc && in_mode == MODE_POINT && {1'b0, in_index} < CntW'(MaxPoints))
            pt_mem[in_index] <= {v2, v1, v0};
        if (in_acc && in_mode == MODE_WEIGHT && {1'b0, in_index} < CntW'(MaxPoints))
            wt_mem[in_index] <= {v2, v1, v0};
        if (in_acc && in_mode == MODE_AFFINE && in_index < IdxW'(3))
            aff_mem[in_index[1:0]] <= {v3, v2, v1, v0};
        pt_rd_reg <= pt_mem[pidx_reg[IdxW-1:0]];
        wt_rd_reg <= wt_mem[pidx_reg[IdxW-1:0]];
    end

    always_comb
    begin
        coef = '0;
        coord = '0;
        pcoord = '0;
        wsel = '0;
        case (term_reg)
            2'd0:
            begin
                coord = qx_reg; pcoord = pt_rd_reg[31:0]; wsel = wt_rd_reg[31:0];
            end
            2'd1:
            begin
                coord = qy_reg; pcoord = pt_rd_reg[63:32]; wsel = wt_rd_reg[63:32];
            end
            2'd2:
            begin
                coord = qz_reg; pcoord = pt_rd_reg[95:64]; wsel = wt_rd_reg[95:64];
            end
            default:
            begin
                coord = '0;
            end
        endcase
        case (term_reg)
            2'd0:    coef = aff_mem[row_reg][63:32];
            2'd1:    coef = aff_mem[row_reg][95:64];
            2'd2:    coef = aff_mem[row_reg][127:96];
            default: coef = '0;
        endcase
    end

    assign dm   = diff_mag(pcoord, coord);
    assign wmag = wsel[31] ? (~wsel + 32'd1) : wsel;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_AFF:
            begin
                mul_a = {coef[31], coef};
                mul_b = {coord[31], coord};
            end
            S_SQ:
            begin
                mul_a = {2'b00, dm};
                mul_b = {2'b00, dm};
            end
            S_DSQ:
            begin
                mul_a = {1'b0, d_reg};
                mul_b = {1'b0, d_reg};
            end
            S_SD:
            begin
                mul_a = part_reg ? {17'd0, s_reg[47:32]} : {1'b0, s_reg[31:0]};
                mul_b = {1'b0, d_reg};
            end
            S_WT:
            begin
                mul_a = part_reg ? {2'b00, u_reg[62:32]} : {1'b0, u_reg[31:0]};
                mul_b = {1'b0, wmag};
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign aff_p = prod_reg[63:0] >> 16 | {{16{prod_reg[63]}}, 48'd0};
    assign full  = wide_reg + {prod_reg[63:0], 32'd0};
    assign rsh   = full[95:16];
    assign rsat  = (rsh > {17'd0, Cap63}) ? Cap63 : rsh[62:0];
    assign wterm = wsel[31] ? (~{1'b0, rsat} + 64'd1) : {1'b0, rsat};
    assign sq_start = (state_reg == S_SQRT) && !phase_reg;

    tps_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sum_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            point_count_reg <= '0;
            pidx_reg        <= '0;
            row_reg         <= '0;
            term_reg        <= '0;
            part_reg        <= 1'b0;
            phase_reg       <= 1'b0;
            qx_reg <= '0; qy_reg <= '0; qz_reg <= '0;
            acc_reg[0] <= '0; acc_reg[1] <= '0; acc_reg[2] <= '0;
            sum_reg <= '0; d_reg <= '0; s_reg <= '0; u_reg <= '0;
            wide_reg <= '0; prod_reg <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;
            if (cfg_valid && cfg_ready)
                point_count_reg <= cfg_data[CntW-1:0];
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {sat_out(acc_reg[2]), sat_out(acc_reg[1]),
                                  sat_out(acc_reg[0])};
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    phase_reg <= 1'b0;
                    part_reg  <= 1'b0;
                    row_reg   <= '0;
                    term_reg  <= '0;
                    pidx_reg  <= '0;
                    if (in_acc && in_mode == MODE_QUERY)
                    begin
                        qx_reg <= v0; qy_reg <= v1; qz_reg <= v2;
                        acc_reg[0] <= {{32{v0[31]}}, v0};
                        acc_reg[1] <= {{32{v1[31]}}, v1};
                        acc_reg[2] <= {{32{v2[31]}}, v2};
                        if (!s_tuser[2])
                            state_reg <= S_AFF;
                        else if (n_pts == '0)
                            state_reg <= S_OUT;
                        else
                            state_reg <= S_RD;
                    end
                end
                S_AFF:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        acc_reg[row_reg] <= aff_p + ((term_reg == 2'd0)
                            ? {{32{aff_mem[row_reg][31]}}, aff_mem[row_reg][31:0]}
                            : acc_reg[row_reg]);
                        if (term_reg == 2'd2)
                        begin
                            term_reg <= '0;
                            if (row_reg == 2'd2)
                                state_reg <= (n_pts == '0) ? S_OUT : S_RD;
                            else
                                row_reg <= row_reg + 2'd1;
                        end
                        else
                            term_reg <= term_reg + 2'd1;
                    end
                end
                S_RD:
                begin
                    phase_reg <= 1'b0;
                    term_reg  <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        sum_reg <= ((term_reg == 2'd0) ? 64'd0 : sum_reg) + prod_reg[63:0];
                        if (term_reg == 2'd2)
                        begin
                            term_reg  <= '0;
                            state_reg <= S_SQRT;
                        end
                        else
                            term_reg <= term_reg + 2'd1;
                    end
                end
                S_SQRT:
                begin
                    if (!phase_reg)
                        phase_reg <= 1'b1;
                    else if (sq_done)
                    begin
                        phase_reg <= 1'b0;
                        d_reg     <= sq_root;
                        state_reg <= S_DSQ;
                    end
                end
                S_DSQ:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        s_reg     <= prod_reg[63:16];
                        part_reg  <= 1'b0;
                        state_reg <= S_SD;
                    end
                end
                S_SD:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        if (!part_reg)
                        begin
                            wide_reg <= {32'd0, prod_reg[63:0]};
                            part_reg <= 1'b1;
                        end
                        else
                        begin
                            u_reg     <= rsat;
                            part_reg  <= 1'b0;
                            term_reg  <= '0;
                            state_reg <= S_WT;
                        end
                    end
                end
                S_WT:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        if (!part_reg)
                        begin
                            wide_reg <= {32'd0, prod_reg[63:0]};
                            part_reg <= 1'b1;
                        end
                        else
                        begin
                            acc_reg[term_reg] <= sat_add64(acc_reg[term_reg], wterm);
                            part_reg <= 1'b0;
                            if (term_reg == 2'd2)
                            begin
                                term_reg <= '0;
                                pidx_reg <= pidx_reg + CntW'(1);
                                state_reg <= (pidx_reg + CntW'(1) == n_pts) ? S_OUT : S_RD;
                            end
                            else
                                term_reg <= term_reg + 2'd1;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

### hdl/tps_isqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on tps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tps_isqrt
    import tps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [35:0] rem_reg;
    logic [31:0] root_reg;
    logic [63:0] rad_reg;
    logic [35:0] rem_sh;
    logic [35:0] test;

    assign rem_sh = {rem_reg[33:0], rad_reg[63:62]};
    assign test   = {2'b00, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            rad_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 5'd0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
                rem_reg  <= '0;
                root_reg <= '0;
                rad_reg  <= radicand;
            end
            else if (busy_reg)
            begin
                if (rem_sh >= test)
                begin
                    rem_reg  <= rem_sh - test;
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
                rad_reg <= {rad_reg[61:0], 2'b00};
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    busy_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

### sim/tb_tps_point_evaluation.sv
// Self-checking testbench for tps_point_evaluation: directed table, then random phases.
// Depends on tps_pkg and the RTL of the evaluator; results are checked against a
// cycle-free predictor of the warp kept inside this file.
`timescale 1ns / 1ps
`default_nettype none
module tb_tps_point_evaluation
    import tps_pkg::*;
();

    localparam int StallLimit = 20000;
    localparam int ItemTarget = 1550;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } warp_t;

    typedef struct {
        logic [1:0]  mode;
        logic [5:0]  idx;
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] v2;
        logic [31:0] v3;
        bit          skip;
        bit          known;
        warp_t       res;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [6:0]   cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;     // index, val_0, val_1, val_2, val_3, zero pad
    logic [2:0]   s_tuser = '0;     // mode, skip_affine
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;          // out_x, out_y, out_z

    int    send_idle = 15;
    int    recv_idle = 50;
    int    hold_cycles = 0;
    int    errors = 0;
    int    items_sent = 0;
    int    stall_count = 0;
    warp_t warp_q[$];

    // predictor state
    int          ctl_x[MaxPoints], ctl_y[MaxPoints], ctl_z[MaxPoints];
    int          wgt_x[MaxPoints], wgt_y[MaxPoints], wgt_z[MaxPoints];
    int          aff[12];
    logic [6:0]  active_points = '0;

    tps_point_evaluation i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 clk = ~clk;

    function automatic logic [31:0] root_floor(logic [63:0] v);
        logic [31:0] r;
        logic [31:0] t;
        r = '0;
        for (int i = 31; i >= 0; i--)
        begin
            t = r | (32'd1 << i);
            if ({32'd0, t} * {32'd0, t} <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [63:0] scale_q16_sat(logic [63:0] a, logic [31:0] b);
        logic [127:0] p;
        p = ({64'd0, a} * {96'd0, b}) >> 16;
        return (p > {65'd0, Cap63}) ? {1'b0, Cap63} : p[63:0];
    endfunction

    function automatic longint add_sat64(longint a, longint b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, Cap63};
        return s[63:0];
    endfunction

    function automatic logic [63:0] dist_mag(int a, int b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        if (d > 64'sd2147483647)
            d = 64'sd2147483647;
        return d;
    endfunction

    function automatic longint affine_sum(int r, int x, int y, int z);
        longint s;
        s = aff[4*r];
        s += (longint'(aff[4*r+1]) * longint'(x)) >>> 16;
        s += (longint'(aff[4*r+2]) * longint'(y)) >>> 16;
        s += (longint'(aff[4*r+3]) * longint'(z)) >>> 16;
        return s;
    endfunction

    function automatic longint weighted(logic [63:0] u, int w);
        logic [31:0] mag;
        logic [63:0] p;
        mag = (w < 0) ? -w : w;
        p = scale_q16_sat(u, mag);
        return (w < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic warp_t warp_point(int x, int y, int z, bit skip);
        longint      ax, ay, az;
        logic [63:0] sq, s, u;
        logic [31:0] d;
        int          n;
        warp_t       w;
        if (skip)
        begin
            ax = x; ay = y; az = z;
        end
        else
        begin
            ax = affine_sum(0, x, y, z);
            ay = affine_sum(1, x, y, z);
            az = affine_sum(2, x, y, z);
        end
        n = (active_points > MaxPoints) ? MaxPoints : active_points;
        for (int i = 0; i < n; i++)
        begin
            sq = dist_mag(ctl_x[i], x) * dist_mag(ctl_x[i], x)
               + dist_mag(ctl_y[i], y) * dist_mag(ctl_y[i], y)
               + dist_mag(ctl_z[i], z) * dist_mag(ctl_z[i], z);
            d = root_floor(sq);
            s = ({32'd0, d} * {32'd0, d}) >> 16;
            u = scale_q16_sat(s, d);
            ax = add_sat64(ax, weighted(u, wgt_x[i]));
            ay = add_sat64(ay, weighted(u, wgt_y[i]));
            az = add_sat64(az, weighted(u, wgt_z[i]));
        end
        w.x = clamp32(ax);
        w.y = clamp32(ay);
        w.z = clamp32(az);
        return w;
    endfunction

    // update stores on an accepted item; queries return their warp
    function automatic bit apply_item(row_t r, output warp_t w);
        w = '{default: '0};
        case (r.mode)
            MODE_POINT:
            begin
                ctl_x[r.idx] = r.v0; ctl_y[r.idx] = r.v1; ctl_z[r.idx] = r.v2;
            end
            MODE_WEIGHT:
            begin
                wgt_x[r.idx] = r.v0; wgt_y[r.idx] = r.v1; wgt_z[r.idx] = r.v2;
            end
            MODE_AFFINE:
            begin
                if (r.idx < 3)
                begin
                    aff[4*r.idx]   = r.v0;
                    aff[4*r.idx+1] = r.v1;
                    aff[4*r.idx+2] = r.v2;
                    aff[4*r.idx+3] = r.v3;
                end
            end
            default:
            begin
                w = warp_point(r.v0, r.v1, r.v2, r.skip);
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic send_item(row_t r);
        warp_t w;
        if ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, r.v3, r.v2, r.v1, r.v0, r.idx};
        s_tuser  <= {r.skip, r.mode};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (apply_item(r, w))
        begin
            if (r.known && (w.x !== r.res.x || w.y !== r.res.y || w.z !== r.res.z))
            begin
                $error("table row predicts %h %h %h, typed %h %h %h",
                       w.x, w.y, w.z, r.res.x, r.res.y, r.res.z);
                errors++;
            end
            warp_q.push_back(r.known ? r.res : w);
        end
    endtask

    task automatic set_point_count(logic [6:0] c);
        s_tvalid <= 1'b0;
        while (warp_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        active_points = c;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return ($urandom_range(0, 1)) ? 32'h7FFFFFFF : 32'h80000000;
            1: return ($urandom_range(0, 1)) ? 32'h0 : 32'hFFFFFFFF;
            2, 3, 4: return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
            default: return $urandom;
        endcase
    endfunction

    function automatic row_t random_row(logic [1:0] mode);
        row_t r;
        r.mode  = mode;
        r.idx   = 6'($urandom_range(0, 63));
        if (mode == MODE_AFFINE && $urandom_range(0, 3) != 0)
            r.idx = 6'($urandom_range(0, 2));
        r.v0    = pick_value();
        r.v1    = pick_value();
        r.v2    = pick_value();
        r.v3    = pick_value();
        r.skip  = 1'($urandom_range(0, 1));
        r.known = 1'b0;
        r.res   = '{default: '0};
        return r;
    endfunction

    // receiver: random stalls plus an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        warp_t got, want;
        if (m_tvalid && m_tready)
        begin
            got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]};
            if (warp_q.size() == 0)
            begin
                $error("unexpected result %h", m_tdata);
                errors++;
            end
            else
            begin
                want = warp_q.pop_front();
                if (got.x !== want.x)
                begin
                    $error("out_x expected %h actual %h", want.x, got.x);
                    errors++;
                end
                if (got.y !== want.y)
                begin
                    $error("out_y expected %h actual %h", want.y, got.y);
                    errors++;
                end
                if (got.z !== want.z)
                begin
                    $error("out_z expected %h actual %h", want.z, got.z);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !rst_n)
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= StallLimit)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        row_t  table_rows[$];
        row_t  r;
        int    phase_items;
        int    roll;
        logic [6:0] c;

        // directed: count 0 after reset, identity-like affine, saturation, ignored rows
        table_rows = '{
            '{MODE_QUERY, 6'd0, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0, 1, 1,
              '{32'h7FFFFFFF, 32'h80000000, 32'h0}},
            '{MODE_QUERY, 6'd63, 32'h00018000, 32'hFFFFFFFF, 32'h12345678, 32'hFFFFFFFF,
              1, 1, '{32'h00018000, 32'hFFFFFFFF, 32'h12345678}},
            '{MODE_AFFINE, 6'd0, 32'h00010000, 32'h00010000, 32'h0, 32'h0, 0, 0,
              '{default: '0}},
            '{MODE_AFFINE, 6'd1, 32'h0, 32'h0, 32'h00010000, 32'h0, 0, 0, '{default: '0}},
            '{MODE_AFFINE, 6'd2, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h00010000, 0, 0,
              '{default: '0}},
            '{MODE_AFFINE, 6'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
              0, 0, '{default: '0}},
            '{MODE_AFFINE, 6'd63, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              1, 0, '{default: '0}},
            '{MODE_QUERY, 6'd0, 32'h00020000, 32'h00030000, 32'h00010000, 32'h0, 0, 1,
              '{32'h00030000, 32'h00030000, 32'h7FFFFFFF}},
            '{MODE_QUERY, 6'd0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFF0000, 32'h0, 0, 1,
              '{32'h7FFFFFFF, 32'h80000000, 32'h7FFEFFFF}},
            '{MODE_QUERY, 6'd0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h0, 0, 1,
              '{32'h80010000, 32'h7FFFFFFF, 32'h7FFFFFFE}},
            '{MODE_POINT, 6'd0, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0, 0, 0,
              '{default: '0}},
            '{MODE_WEIGHT, 6'd0, 32'h80000000, 32'h7FFFFFFF, 32'h00010000, 32'h0, 0, 0,
              '{default: '0}}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
            send_item(table_rows[i]);
        set_point_count(7'd1);
        send_item('{MODE_QUERY, 6'd0, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 1, 0,
                    '{default: '0}});
        send_item('{MODE_QUERY, 6'd0, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0, 0, 0,
                    '{default: '0}});

        // fill every store entry so that no query reads an unwritten one
        for (int i = 0; i < MaxPoints; i++)
        begin
            r = random_row(MODE_POINT);
            r.idx = 6'(i);
            send_item(r);
            r = random_row(MODE_WEIGHT);
            r.idx = 6'(i);
            send_item(r);
        end

        for (int ph = 0; items_sent < ItemTarget; ph++)
        begin
            if (ph % 8 == 5)
            begin
                case ($urandom_range(0, 2))
                    0: c = 7'd64;
                    1: c = 7'd100;
                    default: c = 7'd127;
                endcase
                phase_items = 12;
            end
            else
            begin
                c = (ph % 8 == 1) ? 7'd0 : 7'($urandom_range(1, 8));
                phase_items = 60;
            end
            set_point_count(c);
            if (items_sent < ItemTarget / 3)
            begin
                send_idle = 15; recv_idle = 50;
            end
            else if (items_sent < 2 * ItemTarget / 3)
            begin
                send_idle = 50; recv_idle = 15;
            end
            else
            begin
                send_idle = 0; recv_idle = 0;
            end
            if (ph == 2)
                hold_cycles = 3000;
            for (int k = 0; k < phase_items; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 40)
                    r = random_row(MODE_QUERY);
                else if (roll < 65)
                    r = random_row(MODE_POINT);
                else if (roll < 90)
                    r = random_row(MODE_WEIGHT);
                else
                    r = random_row(MODE_AFFINE);
                send_item(r);
            end
        end

        s_tvalid <= 1'b0;
        while (warp_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

### files.f
hdl/tps_pkg.sv
hdl/tps_isqrt.sv
hdl/tps_point_evaluation.sv
sim/tb_tps_point_evaluation.sv
